// ===== rtl/wgm_pkg.sv =====
// Shared types, constants and helpers for the case-insensitive glob matcher.
// No dependencies; imported by wildcard_glob_match_nocase.
package wgm_pkg;

    // Storage sizing
    localparam int PATTERN_MAX = 16;
    localparam int CHAR_BITS   = 16;
    localparam int POS_N       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(POS_N);
    localparam int LVL_N       = $clog2(POS_N);

    // Port field widths
    localparam int FUNC_W = 2;
    localparam int CH_W   = 16;

    typedef logic [CHAR_BITS-1:0]   char_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [POS_N-1:0]       act_t;
    typedef logic [PATTERN_MAX-1:0] mask_t;

    // Word codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PAT  = 2'd0,
        FUNC_TEXT = 2'd1,
        FUNC_END  = 2'd2
    } func_e;

    // Character constants
    localparam char_t CH_STAR  = char_t'(16'h002A);
    localparam char_t CH_QMARK = char_t'(16'h003F);
    localparam char_t CH_UP_A  = char_t'(16'h0041);
    localparam char_t CH_UP_Z  = char_t'(16'h005A);
    localparam char_t CH_LOW_A = char_t'(16'h0061);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CH_W-1:0]   ch;
        logic              first;
    } in_word_t;

    typedef struct packed {
        logic matched;
        logic pattern_too_long;
    } out_word_t;

    // Keep the low CHAR_BITS bits and fold A-Z to lower case
    function automatic char_t fold_char(logic [CH_W-1:0] raw);
        char_t c;
        c = char_t'(raw);
        if (c >= CH_UP_A && c <= CH_UP_Z)
            c = c - CH_UP_A + CH_LOW_A;
        return c;
    endfunction

    // Close an active set over stars: pos j+1 turns on when j is on and holds a star.
    // Parallel prefix over log2 levels, carry-style (generate = active, propagate = star).
    function automatic act_t close_stars(act_t act, mask_t star);
        act_t g;
        act_t p;
        g = act;
        p = {star, 1'b0};
        for (int lvl = 0; lvl < LVL_N; lvl++) begin
            g = g | (p & (g << (1 << lvl)));
            p = p & (p << (1 << lvl));
        end
        return g;
    endfunction

endpackage

// ===== rtl/wildcard_glob_match_nocase.sv =====
// Top level of the case-insensitive glob matcher: input register, position update, result register.
// Depends on wgm_pkg for word types, codes and the star-closure helper.

// Pattern words load a pattern of up to PATTERN_MAX characters (first=1 starts a new one;
// extra characters are dropped and flagged), text words advance a bit-parallel set of
// active pattern positions, and an end word returns one result (whole-text match and
// overflow flag) and rearms for the next text. Matching folds only A-Z to lower case;
// '*' matches any run, '?' any one character. The block takes one word every cycle: each
// word is handled in a single pass between the input register and the state/result
// registers, so a result is registered once its end word leaves the input register. Only the
// result register can stall the flow, and only while an end word waits for it.
module wildcard_glob_match_nocase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wgm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wgm_pkg::out_word_t out_data
);
    import wgm_pkg::*;

    // Input stage
    logic      in_valid_reg;
    in_word_t  in_word_reg;

    // Matcher state
    char_t     store_reg [PATTERN_MAX];
    char_t     store_next [PATTERN_MAX];
    len_t      len_reg, len_next;
    logic      ovf_reg, ovf_next;
    act_t      act_reg, act_next;

    // Result stage
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    logic      fire;
    logic      is_end;
    char_t     c_in;
    mask_t     star_cur, star_new, hit_cur;
    act_t      step_act, rearm_act;
    len_t      len_base;
    logic      ovf_base;

    assign c_in   = fold_char(in_word_reg.ch);
    assign is_end = (in_word_reg.func == FUNC_END);

    // Process the held word unless it is an end word with the result slot still full
    assign fire     = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Star and per-position hit masks on the current pattern
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star_cur[i] = (len_t'(i) < len_reg) && (store_reg[i] == CH_STAR);
            hit_cur[i]  = (len_t'(i) < len_reg) &&
                          ((store_reg[i] == CH_QMARK) || (store_reg[i] == c_in));
        end
    end

    // Advance the active set by one text character
    always_comb
    begin
        step_act = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (act_reg[i] && star_cur[i])
                step_act[i] = 1'b1;
            else if (act_reg[i] && hit_cur[i])
                step_act[i+1] = 1'b1;
        end
    end

    // Pattern store update
    always_comb
    begin
        len_base   = in_word_reg.first ? '0 : len_reg;
        ovf_base   = in_word_reg.first ? 1'b0 : ovf_reg;
        store_next = store_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        if (fire && in_word_reg.func == FUNC_PAT) begin
            if (len_base < len_t'(PATTERN_MAX)) begin
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    if (len_base == len_t'(i))
                        store_next[i] = c_in;
                end
                len_next = len_base + len_t'(1);
                ovf_next = ovf_base;
            end
            else begin
                len_next = len_base;
                ovf_next = 1'b1;
            end
        end
    end

    // Rearm against the pattern as it stands after this word
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
            star_new[i] = (len_t'(i) < len_next) && (store_next[i] == CH_STAR);
        rearm_act = close_stars(act_t'(1), star_new);
    end

    // Active set and result selection
    always_comb
    begin
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        if (fire) begin
            case (in_word_reg.func)
                FUNC_PAT:
                begin
                    act_next = rearm_act;
                end
                FUNC_TEXT:
                begin
                    act_next = close_stars(step_act, star_cur);
                end
                FUNC_END:
                begin
                    act_next                       = rearm_act;
                    out_valid_next                 = 1'b1;
                    out_word_next.matched          = act_reg[len_reg];
                    out_word_next.pattern_too_long = ovf_reg;
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            act_reg       <= act_t'(1);
        end
        else begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            act_reg       <= act_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
        store_reg    <= store_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= len_t'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == len_t'(PATTERN_MAX)))
        else $error("overflow flagged with room left in the store");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_word_reg.func == FUNC_PAT || is_end)) |=> act_reg[0])
        else $error("active set not rearmed at position zero");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_end) |=> out_valid_reg)
        else $error("end word produced no result");

endmodule
